[src/crc32_frame_parser_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the frame parser
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CRC32_FRAME_PARSER_CORE_DEFINES_SVH
`define CRC32_FRAME_PARSER_CORE_DEFINES_SVH

// Implication in the same cycle.
`define FP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication in the next cycle.
`define FP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/crc32fp_pkg.sv]
// ----------------------------------------------------------------------------
// Frame parser package
// Types, constants and the byte-wide CRC-32 update shared by the parser files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crc32fp_pkg;

	localparam int MAX_PAYLOAD_DEF = 256;

	localparam int HEADER_END = 14;
	localparam int LENGTH_DONE = 6;
	localparam int CRC_BYTES = 4;
	localparam int FRAME_OVERHEAD = HEADER_END + CRC_BYTES;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;
	localparam int IN_TDATA_W = 8;
	localparam int OUT_TDATA_W = 104;
	localparam int OUT_TUSER_W = 4;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

	localparam logic [7:0] START_FIRST_RST = 8'hAA;
	localparam logic [7:0] START_SECOND_RST = 8'h55;
	localparam logic [7:0] VERSION_RST = 8'h01;

	typedef enum logic [2:0] {
		ST_MORE        = 3'd0,
		ST_GOOD        = 3'd1,
		ST_VERSION_ERR = 3'd2,
		ST_CRC_ERR     = 3'd3,
		ST_LENGTH_ERR  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		REG_START_FIRST  = 2'd0,
		REG_START_SECOND = 2'd1,
		REG_VERSION      = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] start_first;
		logic [7:0] start_second;
		logic [7:0] version;
	} cfg_t;

	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h000000, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'h0000_0000);
		end
		return c;
	endfunction

endpackage

[src/crc32fp_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Frame parser configuration registers
// APB register file holding the start bytes and the expected version.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc32fp_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [crc32fp_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [crc32fp_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [crc32fp_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                pready,
	output crc32fp_pkg::cfg_t                   cfg
);
	import crc32fp_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_first  <= START_FIRST_RST;
			cfg_q.start_second <= START_SECOND_RST;
			cfg_q.version      <= VERSION_RST;
		end else if (wr_en) begin
			case (idx)
				REG_START_FIRST:  cfg_q.start_first  <= pwdata[7:0];
				REG_START_SECOND: cfg_q.start_second <= pwdata[7:0];
				REG_VERSION:      cfg_q.version      <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_START_FIRST:  prdata = {24'h000000, cfg_q.start_first};
			REG_START_SECOND: prdata = {24'h000000, cfg_q.start_second};
			REG_VERSION:      prdata = {24'h000000, cfg_q.version};
			default:          prdata = '0;
		endcase
	end

endmodule

[src/crc32_frame_parser_core.sv]
// ----------------------------------------------------------------------------
// CRC-32 frame parser core
// Deframes a byte stream: start bytes, header, cut-through payload, CRC check.
// ----------------------------------------------------------------------------
// The slave stream carries one received byte per transaction. The master stream
// returns exactly one result per accepted byte: tuser holds the status and the
// payload flag, tdata the forwarded payload byte with its index and, on a good
// frame, the type, length, session id and sequence number.
// A result appears on the master side in the cycle after its byte is accepted, and
// while the receiver does not stall, a new byte can be accepted in every cycle, so
// the sustained rate is one byte per cycle. That rate is set by the single stage
// holding the byte-wide CRC-32 update and the frame position counter.
// The result register parts the two sides: while a result is stalled by the
// receiver, no further byte is taken; a byte is taken in the same cycle as the
// stalled result leaves.
// Reset returns the state registers to their defaults and the parser to the hunt for
// the first start byte; no clearing pass is needed.
// Configuration is to be written through the APB port only while the stream is idle; the core does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc32_frame_parser_core #(
	parameter int MAX_PAYLOAD = crc32fp_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [crc32fp_pkg::IN_TDATA_W-1:0]   s_tdata,  // [7:0] rx_byte
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [7:0] payload_byte, [15:8] payload_index, [23:16] packet_type,
	// [32:24] body_len, [64:33] sess_word, [96:65] sequence_number, rest 0
	output logic [crc32fp_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic [crc32fp_pkg::OUT_TUSER_W-1:0]  m_tuser,  // [2:0] status, [3] payload_valid
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [crc32fp_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [crc32fp_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [crc32fp_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                 pready
);
	import crc32fp_pkg::*;

	localparam int POS_W = $clog2(MAX_PAYLOAD + FRAME_OVERHEAD + 1);
	localparam logic [16:0] MAX_LEN = 17'(MAX_PAYLOAD);

	cfg_t cfg;

	crc32fp_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic [POS_W-1:0] pos_q, pos_n;
	logic [POS_W-1:0] frame_end_q, frame_end_n;
	logic [7:0]       version_q, version_n;
	logic [7:0]       type_q, type_n;
	logic [15:0]      length_q, length_n;
	logic [31:0]      session_q, session_n;
	logic [31:0]      sequence_q, sequence_n;
	logic [31:0]      crc_q, crc_n;
	logic [31:0]      rx_crc_q, rx_crc_n;

	status_t          res_status;
	logic             res_pvalid;
	logic [7:0]       res_pbyte;
	logic [7:0]       res_pindex;
	logic [7:0]       res_type;
	logic [8:0]       res_length;
	logic [31:0]      res_session;
	logic [31:0]      res_sequence;

	logic             out_valid_q;
	status_t          out_status_q;
	logic             out_pvalid_q;
	logic [7:0]       out_pbyte_q;
	logic [7:0]       out_pindex_q;
	logic [7:0]       out_type_q;
	logic [8:0]       out_length_q;
	logic [31:0]      out_session_q;
	logic [31:0]      out_sequence_q;

	logic [7:0]       b;
	logic             take;
	logic             restart;
	logic             restart_first;
	logic [15:0]      len_full;
	logic [POS_W-1:0] pay_end;
	logic [POS_W-1:0] hdr_off;
	logic [POS_W-1:0] crc_off;
	logic [POS_W-1:0] pay_off;
	logic [31:0]      crc_upd;

	assign b        = s_tdata[7:0];
	assign s_tready = !out_valid_q || m_tready;
	assign take     = s_tvalid && s_tready;
	assign len_full = {b, length_q[7:0]};
	assign pay_end  = POS_W'(HEADER_END) + POS_W'(length_q);
	assign hdr_off  = pos_q - POS_W'(LENGTH_DONE);
	assign crc_off  = pos_q - pay_end;
	assign pay_off  = pos_q - POS_W'(HEADER_END);
	assign crc_upd  = crc32_byte(crc_q, b);

	always_comb begin
		pos_n         = pos_q;
		frame_end_n   = frame_end_q;
		version_n     = version_q;
		type_n        = type_q;
		length_n      = length_q;
		session_n     = session_q;
		sequence_n    = sequence_q;
		crc_n         = crc_q;
		rx_crc_n      = rx_crc_q;
		res_status    = ST_MORE;
		res_pvalid    = 1'b0;
		res_pbyte     = '0;
		res_pindex    = '0;
		res_type      = '0;
		res_length    = '0;
		res_session   = '0;
		res_sequence  = '0;
		restart       = 1'b0;
		restart_first = 1'b0;

		if (pos_q == '0) begin
			if (b == cfg.start_first) begin
				pos_n = POS_W'(1);
			end
		end else if (pos_q == POS_W'(1)) begin
			if (b == cfg.start_second) begin
				pos_n = POS_W'(2);
			end else begin
				restart       = 1'b1;
				restart_first = (b == cfg.start_first);
			end
		end else begin
			pos_n = pos_q + POS_W'(1);
			if (pos_q < POS_W'(LENGTH_DONE)) begin
				crc_n = crc_upd;
				case (pos_q[2:0])
					3'd2: version_n = b;
					3'd3: type_n = b;
					3'd4: length_n = {8'h00, b};
					default: begin
						length_n = len_full;
						if ({1'b0, len_full} > MAX_LEN) begin
							restart    = 1'b1;
							res_status = ST_LENGTH_ERR;
						end else begin
							frame_end_n = POS_W'(FRAME_OVERHEAD) + POS_W'(len_full);
						end
					end
				endcase
			end else begin
				if (pos_q < POS_W'(HEADER_END)) begin
					crc_n = crc_upd;
					if (pos_q < POS_W'(LENGTH_DONE + 4)) begin
						session_n[8*hdr_off[1:0] +: 8] = b;
					end else begin
						sequence_n[8*hdr_off[1:0] +: 8] = b;
					end
				end else if (pos_q < pay_end) begin
					crc_n      = crc_upd;
					res_pvalid = 1'b1;
					res_pbyte  = b;
					res_pindex = pay_off[7:0];
				end else begin
					rx_crc_n[8*crc_off[1:0] +: 8] = b;
				end

				if (pos_n == frame_end_q) begin
					restart = 1'b1;
					if (version_q != cfg.version) begin
						res_status = ST_VERSION_ERR;
					end else if ((crc_n ^ 32'hFFFF_FFFF) != rx_crc_n) begin
						res_status = ST_CRC_ERR;
					end else begin
						res_status   = ST_GOOD;
						res_type     = type_q;
						res_length   = length_q[8:0];
						res_session  = session_q;
						res_sequence = sequence_q;
					end
				end
			end
		end

		if (restart) begin
			pos_n       = restart_first ? POS_W'(1) : '0;
			frame_end_n = '0;
			version_n   = '0;
			type_n      = '0;
			length_n    = '0;
			session_n   = '0;
			sequence_n  = '0;
			crc_n       = 32'hFFFF_FFFF;
			rx_crc_n    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			frame_end_q <= '0;
			version_q   <= '0;
			type_q      <= '0;
			length_q    <= '0;
			session_q   <= '0;
			sequence_q  <= '0;
			crc_q       <= 32'hFFFF_FFFF;
			rx_crc_q    <= '0;
			out_valid_q <= 1'b0;
		end else if (take) begin
			pos_q       <= pos_n;
			frame_end_q <= frame_end_n;
			version_q   <= version_n;
			type_q      <= type_n;
			length_q    <= length_n;
			session_q   <= session_n;
			sequence_q  <= sequence_n;
			crc_q       <= crc_n;
			rx_crc_q    <= rx_crc_n;
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_status_q   <= res_status;
			out_pvalid_q   <= res_pvalid;
			out_pbyte_q    <= res_pbyte;
			out_pindex_q   <= res_pindex;
			out_type_q     <= res_type;
			out_length_q   <= res_length;
			out_session_q  <= res_session;
			out_sequence_q <= res_sequence;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = {out_pvalid_q, out_status_q};
	assign m_tdata  = {7'h00, out_sequence_q, out_session_q, out_length_q,
	                   out_type_q, out_pindex_q, out_pbyte_q};

endmodule

[src/crc32fp_checker.sv]
// ----------------------------------------------------------------------------
// Frame parser port checker
// Watches the master stream of the parser core for consistent results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "crc32_frame_parser_core_defines.svh"

module crc32fp_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 m_tvalid,
	input logic                                 m_tready,
	input logic [crc32fp_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input logic [crc32fp_pkg::OUT_TUSER_W-1:0]  m_tuser
);
	import crc32fp_pkg::*;

	`FP_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
	`FP_ASSERT_SAME(a_payload_zero, m_tvalid && !m_tuser[3], m_tdata[15:0] == 16'h0000, "payload fields set without payload flag")
	`FP_ASSERT_SAME(a_packet_zero, m_tvalid && (m_tuser[2:0] != ST_GOOD), m_tdata[103:16] == '0, "packet fields set without good status")
	`FP_ASSERT_SAME(a_payload_more, m_tvalid && m_tuser[3], m_tuser[2:0] == ST_MORE, "payload byte carries a final status")

endmodule

bind crc32_frame_parser_core crc32fp_checker u_checker (.*);
